@@ hw/rtl/ilid_pkg.sv @@
// Shared types and constants for the indexed list insert/delete core.
// Used by ilid_ctrl, ilid_datapath and indexed_list_insert_delete_core.
package ilid_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int TYPE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 7;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_READ   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_HEAD   = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_TAIL   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_AT     = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0]        req_type;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
      logic [LENGTH_W-1:0]      length;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // latch request, status and start pointer
      logic rd_req;      // read memory at the request position
      logic rd_dn;       // read memory at pointer - 1
      logic rd_up;       // read memory at pointer + 1
      logic wr_move;     // write read data at pointer
      logic wr_put;      // write request value at insert slot
      logic ptr_dec;
      logic ptr_inc;
      logic cnt_inc;
      logic cnt_dec;
      logic resp_read;   // send read data as the result
      logic resp_plain;  // send latched status as the result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic read_ok;
      logic ins_ok;
      logic del_ok;
      logic ins_more;
      logic del_more;
   } stat_type;

endpackage

@@ hw/rtl/ilid_ctrl.sv @@
// Sequencer for the indexed list core: decides each request's steps.
// Depends on ilid_pkg; drives ilid_datapath through cmd_type.
module ilid_ctrl
   import ilid_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_RD_DONE  = 7'b0000010,
      S_INS_LOOP = 7'b0000100,
      S_INS_MOVE = 7'b0001000,
      S_DEL_LOOP = 7'b0010000,
      S_DEL_MOVE = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load   = 1'b1;
               cmd.rd_req = 1'b1;
               if (stat.read_ok) begin
                  state_in = S_RD_DONE;
               end else if (stat.ins_ok) begin
                  state_in = S_INS_LOOP;
               end else if (stat.del_ok) begin
                  state_in = S_DEL_LOOP;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RD_DONE: begin
            cmd.resp_read = 1'b1;
            state_in      = S_IDLE;
         end
         S_INS_LOOP: begin
            if (stat.ins_more) begin
               cmd.rd_dn = 1'b1;
               state_in  = S_INS_MOVE;
            end else begin
               cmd.wr_put  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_INS_MOVE: begin
            cmd.wr_move = 1'b1;
            cmd.ptr_dec = 1'b1;
            state_in    = S_INS_LOOP;
         end
         S_DEL_LOOP: begin
            if (stat.del_more) begin
               cmd.rd_up = 1'b1;
               state_in  = S_DEL_MOVE;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_DEL_MOVE: begin
            cmd.wr_move = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = S_DEL_LOOP;
         end
         S_RESP: begin
            cmd.resp_plain = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ilid_datapath.sv @@
// Entry memory, length counter, move pointer and result registers.
// Depends on ilid_pkg; steered by ilid_ctrl through cmd_type.
module ilid_datapath
   import ilid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)(
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  cmd_type      cmd,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic signed [DATA_W-1:0] entry_mem [CAPACITY];
   logic signed [DATA_W-1:0] mem_q_ff;

   logic [CW-1:0]            count_ff, count_in;
   logic [PW-1:0]            ptr_ff, ptr_in;
   logic [PW-1:0]            at_ff, at_in;
   logic signed [DATA_W-1:0] value_ff;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     rsp_valid_ff;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   logic [PW-1:0]            pos_ext, count_ext, ptr_dn, ptr_up;
   logic                     full;
   logic                     mem_we;
   logic [AW-1:0]            mem_ra, mem_wa;
   logic signed [DATA_W-1:0] mem_wd;

   assign pos_ext   = PW'(req_item.position);
   assign count_ext = PW'(count_ff);
   assign full      = (count_ff == CW'(CAPACITY));
   assign ptr_dn    = ptr_ff - 1'b1;
   assign ptr_up    = ptr_ff + 1'b1;

   // classify the incoming request against the current length
   always_comb begin
      stat.read_ok  = 1'b0;
      stat.ins_ok   = 1'b0;
      stat.del_ok   = 1'b0;
      stat.ins_more = (ptr_ff > at_ff);
      stat.del_more = (ptr_up < count_ext);
      status_in     = ST_DONE;
      at_in         = pos_ext;
      ptr_in        = pos_ext;
      case (req_item.req_type)
         REQ_READ: begin
            stat.read_ok = (pos_ext < count_ext);
            if (!stat.read_ok) begin
               status_in = ST_INVALID;
            end
         end
         REQ_HEAD, REQ_TAIL, REQ_AT: begin
            if (req_item.req_type == REQ_HEAD) begin
               at_in = '0;
            end else if (req_item.req_type == REQ_TAIL) begin
               at_in = count_ext;
            end
            ptr_in = count_ext;
            if (at_in > count_ext) begin
               status_in = ST_INVALID;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               stat.ins_ok = 1'b1;
            end
         end
         REQ_DELETE: begin
            stat.del_ok = (pos_ext < count_ext);
            if (!stat.del_ok) begin
               status_in = ST_INVALID;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // single write port, single registered read port
   always_comb begin
      if (cmd.rd_req) begin
         mem_ra = pos_ext[AW-1:0];
      end else if (cmd.rd_dn) begin
         mem_ra = ptr_dn[AW-1:0];
      end else begin
         mem_ra = ptr_up[AW-1:0];
      end
      mem_we = cmd.wr_move | cmd.wr_put;
      mem_wa = cmd.wr_put ? at_ff[AW-1:0] : ptr_ff[AW-1:0];
      mem_wd = cmd.wr_put ? value_ff : mem_q_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= entry_mem[mem_ra];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_item_in.read_value = cmd.resp_read ? mem_q_ff : '0;
      rsp_item_in.status     = cmd.resp_read ? ST_DONE : status_ff;
      rsp_item_in.length     = count_ext[LENGTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.resp_read | cmd.resp_plain;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         at_ff     <= at_in;
         value_ff  <= req_item.value;
         status_ff <= status_in;
         ptr_ff    <= ptr_in;
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_dn;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_up;
      end
      if (cmd.resp_read | cmd.resp_plain) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length beyond capacity");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !full)
      else $error("insert committed into a full list");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> (count_ff != '0))
      else $error("delete committed on an empty list");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_move && cmd.wr_put))
      else $error("two memory writes in one cycle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

endmodule

@@ hw/rtl/indexed_list_insert_delete_core.sv @@
// Top level of the indexed list core: ordered list of signed words with
// read, insert and delete by position. Depends on ilid_pkg, ilid_ctrl and
// ilid_datapath.
//
// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown on rsp_item for one cycle with rsp_valid high, and
// the receiver cannot stall it. Entries live in a single-port memory (one
// write, one registered read per cycle), so insert and delete move the later
// entries one at a time, each by a read and then a write. With n entries in
// the list, a read, a refused request or an unknown code moves no entry, an
// insert at position p (head: p = 0, tail: p = n) moves the n-p entries from
// p upward, and a delete at p moves the n-p-1 entries after p down. The
// result strobe is high in the first cycle in which busy is low again, so the
// next request can be taken at the edge that ends it. No clearing pass is
// needed after reset.
module indexed_list_insert_delete_core
   import ilid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   cmd_type  cmd;
   stat_type stat;

   ilid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ilid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for indexed_list_insert_delete_core: a queue-fed
// driver, a monitor that predicts each result from its own copy of the list,
// and a watchdog. Depends on ilid_pkg and the core.
module testbench;
   import ilid_pkg::*;

   localparam int LIST_CAP     = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1700;
   localparam int QUIET_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 8;

   typedef struct {
      req_item_type item;
      bit           hold;   // wait for every result before this transfer
   } pending_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   pending_type  pending_reqs[$];
   rsp_item_type expected_rsps[$];

   // monitor's copy of the list
   logic signed [DATA_W-1:0] list_words[LIST_CAP];
   int list_len = 0;

   int gen_len = 0;      // list length as tracked while building stimulus
   int rsp_owed = 0;
   int gap_left = 0;
   int calm_left = 0;
   int quiet_cycles = 0;
   bit timed_out = 1'b0;
   int errors = 0;
   int n_done_ins = 0, n_done_del = 0, n_full = 0, n_invalid = 0, peak_len = 0;

   indexed_list_insert_delete_core #(.CAPACITY(LIST_CAP)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the list copy and return the result it should give.
   function automatic rsp_item_type apply_request(req_item_type r);
      rsp_item_type o;
      int slot;
      int i;
      o = '0;
      o.status = ST_DONE;
      case (r.req_type)
         REQ_READ: begin
            if (r.position < list_len) o.read_value = list_words[r.position];
            else o.status = ST_INVALID;
         end
         REQ_HEAD, REQ_TAIL, REQ_AT: begin
            slot = (r.req_type == REQ_HEAD) ? 0 :
                   (r.req_type == REQ_TAIL) ? list_len : int'(r.position);
            if (slot > list_len) begin
               o.status = ST_INVALID;
            end else if (list_len >= LIST_CAP) begin
               o.status = ST_FULL;
            end else begin
               for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
               list_words[slot] = r.value;
               list_len++;
            end
         end
         REQ_DELETE: begin
            if (r.position < list_len) begin
               for (i = r.position; i < list_len - 1; i++) list_words[i] = list_words[i+1];
               list_len--;
            end else begin
               o.status = ST_INVALID;
            end
         end
         default: ;
      endcase
      o.length = list_len[LENGTH_W-1:0];
      return o;
   endfunction

   task automatic add_req(input logic [TYPE_W-1:0] kind, input int pos,
                          input logic [DATA_W-1:0] val, input bit hold);
      pending_type p;
      p.item.req_type = kind;
      p.item.position = pos[POS_W-1:0];
      p.item.value    = val;
      p.hold          = hold;
      pending_reqs.push_back(p);
      case (kind)
         REQ_HEAD, REQ_TAIL: if (gen_len < LIST_CAP) gen_len++;
         REQ_AT:             if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
         REQ_DELETE:         if (pos < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   // Driver: present queued requests, idle a random number of cycles after
   // each transfer.
   always @(posedge clock) begin
      int next_gap;
      pending_type p;
      if (reset) begin
         start     <= 1'b0;
         req_item  <= '0;
         gap_left  <= 0;
         calm_left <= 0;
      end else if (start && !busy) begin
         if (calm_left > 0) begin
            next_gap = 0;
            calm_left <= calm_left - 1;
         end else begin
            next_gap = $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0) calm_left <= $urandom_range(10, 40);
         end
         if (next_gap == 0 && pending_reqs.size() != 0 && !pending_reqs[0].hold) begin
            p = pending_reqs.pop_front();
            req_item <= p.item;
         end else begin
            start    <= 1'b0;
            gap_left <= next_gap;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_reqs.size() != 0 &&
                      (!pending_reqs[0].hold || rsp_owed == 0)) begin
            p = pending_reqs.pop_front();
            req_item <= p.item;
            start    <= 1'b1;
         end
      end
   end

   // Monitor: check each result against the oldest prediction, then record
   // the prediction for a request taken at this edge.
   always @(posedge clock) begin
      int got;
      int took;
      rsp_item_type want;
      if (!reset) begin
         got  = 0;
         took = 0;
         if (rsp_valid) begin
            got = 1;
            if (expected_rsps.size() == 0) begin
               $error("result with no request outstanding: read_value %0d status %0d length %0d",
                      rsp_item.read_value, rsp_item.status, rsp_item.length);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_item.read_value);
                  errors++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  errors++;
               end
               if (rsp_item.length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_item.length);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            took = 1;
            want = apply_request(req_item);
            expected_rsps.push_back(want);
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_INVALID) n_invalid++;
            if (want.status == ST_DONE && req_item.req_type inside {REQ_HEAD, REQ_TAIL, REQ_AT})
               n_done_ins++;
            if (want.status == ST_DONE && req_item.req_type == REQ_DELETE) n_done_del++;
            if (list_len > peak_len) peak_len = list_len;
         end
         if (took != got) rsp_owed <= rsp_owed + took - got;
      end
   end

   // Watchdog: give up after a long stretch with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) timed_out <= 1'b1;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int made;
      int run;
      int mode;
      int k;
      int r;
      int pos;
      int ins_pct;
      int del_pct;
      bit hold;
      bit first;
      logic [TYPE_W-1:0] kind;
      logic [DATA_W-1:0] val;

      // Directed: empty list, unused codes, value extremes, edge positions.
      add_req(REQ_READ,   0,   32'h1234_5678, 1'b0);
      add_req(REQ_DELETE, 0,   32'h0,         1'b0);
      add_req(REQ_AT,     1,   32'h5,         1'b0);
      add_req(REQ_DELETE + 3'd1, 0,   32'hFFFF_FFFF, 1'b0);  // codes above delete are unused
      add_req(REQ_DELETE + 3'd2, 255, 32'h0,         1'b0);
      add_req(REQ_DELETE + 3'd3, 128, 32'h8000_0000, 1'b0);
      add_req(REQ_TAIL,   255, 32'h7FFF_FFFF, 1'b0);
      add_req(REQ_HEAD,   255, 32'h8000_0000, 1'b0);
      add_req(REQ_AT,     1,   32'h0,         1'b0);
      add_req(REQ_AT,     3,   32'hFFFF_FFFF, 1'b0);   // position equal to length appends
      add_req(REQ_AT,     5,   32'h1,         1'b0);
      add_req(REQ_AT,     255, 32'h2,         1'b0);
      add_req(REQ_READ,   0,   32'h0,         1'b0);
      add_req(REQ_READ,   1,   32'h0,         1'b0);
      add_req(REQ_READ,   2,   32'h0,         1'b0);
      add_req(REQ_READ,   3,   32'h0,         1'b0);
      add_req(REQ_READ,   4,   32'h0,         1'b0);
      add_req(REQ_READ,   255, 32'hFFFF_FFFF, 1'b0);
      add_req(REQ_DELETE, 3,   32'h0,         1'b0);
      add_req(REQ_DELETE, 0,   32'h0,         1'b0);
      add_req(REQ_DELETE, 255, 32'h0,         1'b0);
      add_req(REQ_DELETE, 2,   32'h0,         1'b0);
      add_req(REQ_READ,   0,   32'h0,         1'b0);
      add_req(REQ_READ,   1,   32'h0,         1'b0);

      // Random: phases that grow, shrink or churn the list.
      made  = 0;
      first = 1'b1;
      while (made < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(20, 120);
         hold = first || ($urandom_range(0, 3) == 0);
         first = 1'b0;
         ins_pct = (mode <= 1) ? 65 : (mode == 2) ? 12 : 35;
         del_pct = (mode <= 1) ? 12 : (mode == 2) ? 65 : 35;
         for (k = 0; k < run; k++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) kind = REQ_HEAD + TYPE_W'($urandom_range(0, 2));
            else if (r < ins_pct + del_pct) kind = REQ_DELETE;
            else if (r < 97) kind = REQ_READ;
            else kind = REQ_DELETE + TYPE_W'($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0 || (gen_len == 0 && kind != REQ_AT))
               pos = $urandom_range(0, 255);
            else if (kind == REQ_AT)
               pos = $urandom_range(0, gen_len);
            else
               pos = $urandom_range(0, gen_len - 1);
            case ($urandom_range(0, 15))
               0:       val = 32'h7FFF_FFFF;
               1:       val = 32'h8000_0000;
               2:       val = 32'h0;
               3:       val = 32'hFFFF_FFFF;
               default: val = $urandom;
            endcase
            add_req(kind, pos, val, hold && (k == 0));
            made++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (!timed_out && !(pending_reqs.size() == 0 && !start && rsp_owed == 0))
         @(negedge clock);
      if (timed_out) begin
         $display("Testbench completed WITH ERRORS");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (expected_rsps.size() != 0) begin
            $error("%0d results never arrived", expected_rsps.size());
            errors++;
         end
         $display("Covered %0d inserts, %0d deletes, %0d full refusals, %0d bad positions;",
                  n_done_ins, n_done_del, n_full, n_invalid);
         $display("longest list held %0d of %0d entries.", peak_len, LIST_CAP);
         if (errors == 0) begin
            $display("Testbench completed without errors");
         end else begin
            $display("Testbench completed WITH ERRORS");
         end
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ilid_pkg.sv
hw/rtl/ilid_ctrl.sv
hw/rtl/ilid_datapath.sv
hw/rtl/indexed_list_insert_delete_core.sv
tb/testbench.sv
